// ===== rtl/oidp_pkg.sv =====
// Shared types and constants for the dotted object identifier text parser.
// Used by oidp_step, oidp_rfifo and oid_dotted_text_parser_core; no dependencies.
package oidp_pkg;

	localparam int unsigned MAX_SUBIDS = 128;
	localparam int unsigned CNT_W      = 7;   // completed-subidentifier count, at most 127
	localparam int unsigned RQ_DEPTH   = 4;   // result queue entries
	localparam int unsigned RQ_PTR_W   = 2;
	localparam int unsigned RQ_CNT_W   = 3;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [7:0] MAX_SUBIDS_RST = 8'(MAX_SUBIDS);
	localparam logic [7:0] MIN_SUBIDS     = 8'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_FIRST_ARC = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0]      accum;
		logic [CNT_W-1:0] count;
		logic             hex;
		logic             after_dot;
		logic             dot_zero;
		logic             first_over;
		status_t          err;
	} parse_state_t;

	typedef struct packed {
		logic [31:0]      value;
		logic [CNT_W-1:0] index;
		logic             valid;
		logic             eoo;
		status_t          status;
	} result_t;

endpackage

// ===== rtl/oidp_step.sv =====
// Next-state and result logic for one character of the parser.
// Purely combinational; depends on oidp_pkg.
module oidp_step (
	input  oidp_pkg::parse_state_t st,
	input  logic [7:0]             ch,
	input  logic                   last,
	input  logic [7:0]             lim,
	output oidp_pkg::parse_state_t nxt,
	output oidp_pkg::result_t      res_a,
	output oidp_pkg::result_t      res_b,
	output logic [1:0]             n_res
);
	import oidp_pkg::*;

	logic             is_sep;
	logic             is_x;
	logic             dig_ok;
	logic [3:0]       dig;
	logic             sep_emit;
	parse_state_t     mid;
	result_t          sep_res;
	result_t          fin_res;
	logic             fin_over;
	logic [CNT_W:0]   cnt_p2;

	always_comb begin
		dig_ok = 1'b0;
		dig    = 4'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			dig_ok = 1'b1;
			dig    = 4'(ch - CH_ZERO);
		end else if (st.hex && ch >= CH_LA && ch <= CH_LF) begin
			dig_ok = 1'b1;
			dig    = 4'(ch - CH_LA + 8'd10);
		end else if (st.hex && ch >= CH_UA && ch <= CH_UF) begin
			dig_ok = 1'b1;
			dig    = 4'(ch - CH_UA + 8'd10);
		end
	end

	assign is_sep = (ch == CH_DOT) || (ch == CH_COLON);
	assign is_x   = (ch == CH_X) && st.dot_zero;
	assign cnt_p2 = {1'b0, st.count} + (CNT_W+1)'(2);

	always_comb begin
		mid      = st;
		sep_emit = 1'b0;
		sep_res  = '{value: st.accum, index: st.count, valid: 1'b1, eoo: 1'b0, status: ST_OK};
		if (st.err == ST_OK) begin
			priority if (is_sep) begin
				sep_emit = 1'b1;
				if (st.count == '0)
					mid.first_over = (st.accum > 32'd2);
				if (cnt_p2 > lim)
					mid.err = ST_TOO_LONG;
				else
					mid.count = st.count + CNT_W'(1);
				mid.accum     = '0;
				mid.hex       = (ch == CH_COLON);
				mid.after_dot = (ch == CH_DOT);
				mid.dot_zero  = 1'b0;
			end else if (is_x) begin
				mid.hex       = 1'b1;
				mid.after_dot = 1'b0;
				mid.dot_zero  = 1'b0;
			end else if (!dig_ok) begin
				mid.err = ST_BAD_CHAR;
			end else begin
				mid.dot_zero  = st.after_dot && (ch == CH_ZERO);
				mid.after_dot = 1'b0;
				if (st.hex)
					mid.accum = {st.accum[27:0], dig};
				else
					mid.accum = (st.accum << 3) + (st.accum << 1) + {28'd0, dig};
			end
		end
	end

	// The final result: the open subidentifier with a status, or the latched error alone.
	always_comb begin
		fin_over = (mid.count == '0) ? (mid.accum > 32'd2) : mid.first_over;
		if (mid.err == ST_OK) begin
			fin_res.value = mid.accum;
			fin_res.index = mid.count;
			fin_res.valid = 1'b1;
			fin_res.eoo   = 1'b1;
			if (mid.count == '0)
				fin_res.status = ST_TOO_SHORT;
			else if (fin_over)
				fin_res.status = ST_FIRST_ARC;
			else
				fin_res.status = ST_OK;
		end else begin
			fin_res = '{value: '0, index: '0, valid: 1'b0, eoo: 1'b1, status: mid.err};
		end
	end

	always_comb begin
		nxt   = last ? parse_state_t'('0) : mid;
		res_a = sep_emit ? sep_res : fin_res;
		res_b = fin_res;
		n_res = 2'({1'b0, sep_emit} + {1'b0, last});
	end

endmodule

// ===== rtl/oidp_rfifo.sv =====
// Small result queue that takes up to two results per cycle and gives one.
// Depends on oidp_pkg.
module oidp_rfifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  oidp_pkg::result_t push_a,
	input  oidp_pkg::result_t push_b,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output oidp_pkg::result_t out_res
);
	import oidp_pkg::*;

	result_t             mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_q;
	logic [RQ_PTR_W-1:0] rd_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem[rd_q];
	assign pop       = out_valid && out_ready;
	// Room for the worst case of two results, judged on the registered fill level.
	assign room      = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_q] <= push_a;
		if (push_n == 2'd2)
			mem[wr_q + RQ_PTR_W'(1)] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_PTR_W'(push_n);
			if (pop)
				rd_q <= rd_q + RQ_PTR_W'(1);
			cnt_q <= cnt_q + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue overfilled");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("results pushed without room");

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd0 && !pop) |=> $stable(cnt_q))
		else $error("fill level moved without a push or pop");

endmodule

// ===== rtl/oid_dotted_text_parser_core.sv =====
// Top level of the dotted object identifier text parser: input register,
// parser state, limit register and result queue. Depends on oidp_pkg,
// oidp_step and oidp_rfifo.
//
//  channel   | direction | tdata / data              | tuser        | tlast
//  s_axis    | in        | [7:0] text_char           | -            | is_last
//  m_axis    | out       | [31:0] subid_value,       | subid_valid  | end_of_oid
//            |           | [38:32] subid_index,      |              |
//            |           | [41:39] parse_status      |              |
//  cfg       | in        | [7:0] max_subids          | -            | -
//
// One character is taken per cycle into the input register while the queue has room.
// It is parsed once the queue has room, and its results (none, one, or two for a
// trailing separator) enter a four-entry queue. The output gives one result per cycle
// while m_axis_tready is high. Reset clears the parser state and sets the limit to
// 128. A held character waits while three or more results are queued, so a stalled
// output stops the input once three results wait.
module oid_dotted_text_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] subid_value, [38:32] subid_index,
	                                    // [41:39] parse_status, [47:42] zero
	output logic        m_axis_tuser,   // [0] subid_valid
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import oidp_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         take;
	logic         room;
	logic [7:0]   max_subids_q;
	logic [7:0]   lim;
	parse_state_t st_q;
	parse_state_t st_nxt;
	result_t      res_a;
	result_t      res_b;
	result_t      out_res;
	logic [1:0]   n_res;
	logic [1:0]   push_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_subids_q <= MAX_SUBIDS_RST;
		else if (cfg_valid && cfg_ready)
			max_subids_q <= cfg_data;
	end

	always_comb begin
		if (max_subids_q < MIN_SUBIDS)
			lim = MIN_SUBIDS;
		else if (max_subids_q > MAX_SUBIDS_RST)
			lim = MAX_SUBIDS_RST;
		else
			lim = max_subids_q;
	end

	assign take          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tvalid && s_axis_tready)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	oidp_step u_step (
		.st    (st_q),
		.ch    (char_s1),
		.last  (last_s1),
		.lim   (lim),
		.nxt   (st_nxt),
		.res_a (res_a),
		.res_b (res_b),
		.n_res (n_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (take)
			st_q <= st_nxt;
	end

	assign push_n = take ? n_res : 2'd0;

	oidp_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.status, out_res.index, out_res.value};
	assign m_axis_tuser = out_res.valid;
	assign m_axis_tlast = out_res.eoo;

	// Once an error is latched, only the status-only final result may follow.
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && st_q.err != ST_OK) |-> (n_res == 2'd0 || (!res_a.valid && res_a.eoo)))
		else $error("subidentifier emitted after an error");

	a_status_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && out_res.status != ST_OK))
		else $error("status-only result that is not a final error");

	a_held_char: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> (valid_s1 && $stable(char_s1) && $stable(last_s1)))
		else $error("held character lost while stalled");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_s1) |=> (st_q == parse_state_t'('0)))
		else $error("parser state not cleared after the final character");

endmodule

// ===== sim/oid_dotted_text_parser_core_tb.sv =====
// Self-checking bench for oid_dotted_text_parser_core: streams dotted identifier strings in,
// predicts every subidentifier and final status, and checks each output request against them.
// Depends on oidp_pkg and the parser RTL only.
module oid_dotted_text_parser_core_tb;
	import oidp_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	oid_dotted_text_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted parser state and the limit register as the bench believes it to be.
	logic [7:0]  limit_reg = MAX_SUBIDS_RST;
	logic [31:0] oid_accum = '0;
	logic [7:0]  oid_count = '0;
	logic        oid_hex = 1'b0;
	logic        oid_after_dot = 1'b0;
	logic        oid_dot_zero = 1'b0;
	logic        oid_first_over = 1'b0;
	status_t     oid_err = ST_OK;

	result_t     pending_subids[$];
	text_item_t  char_backlog[$];
	logic [7:0]  oid_text[$];
	int          mismatch_count = 0;
	int          phase_items = 0;

	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          rx_hold_left = 0;
	text_item_t  tx_item;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic push_subid(input logic [31:0] value, input logic [7:0] idx,
	                          input logic valid, input logic eoo, input status_t status);
		result_t r;
		r.value  = value;
		r.index  = idx[CNT_W-1:0];
		r.valid  = valid;
		r.eoo    = eoo;
		r.status = status;
		pending_subids.push_back(r);
	endtask

	task automatic parse_char(input logic [7:0] ch, input logic last);
		logic [7:0] lim;
		int         dv;
		status_t    fin;
		if (limit_reg < MIN_SUBIDS)
			lim = MIN_SUBIDS;
		else if (limit_reg > MAX_SUBIDS_RST)
			lim = MAX_SUBIDS_RST;
		else
			lim = limit_reg;

		if (oid_err == ST_OK) begin
			if (ch == CH_DOT || ch == CH_COLON) begin
				push_subid(oid_accum, oid_count, 1'b1, 1'b0, ST_OK);
				if (oid_count == 0)
					oid_first_over = oid_accum > 32'd2;
				if ({1'b0, oid_count} + 9'd2 > {1'b0, lim})
					oid_err = ST_TOO_LONG;
				else
					oid_count = oid_count + 8'd1;
				oid_accum     = '0;
				oid_hex       = (ch == CH_COLON);
				oid_after_dot = (ch == CH_DOT);
				oid_dot_zero  = 1'b0;
			end else if (ch == CH_X && oid_dot_zero) begin
				oid_hex       = 1'b1;
				oid_after_dot = 1'b0;
				oid_dot_zero  = 1'b0;
			end else begin
				if (ch >= CH_ZERO && ch <= CH_NINE)
					dv = int'(ch) - int'(CH_ZERO);
				else if (oid_hex && ch >= CH_LA && ch <= CH_LF)
					dv = int'(ch) - int'(CH_LA) + 10;
				else if (oid_hex && ch >= CH_UA && ch <= CH_UF)
					dv = int'(ch) - int'(CH_UA) + 10;
				else
					dv = -1;
				if (dv < 0) begin
					oid_err = ST_BAD_CHAR;
				end else begin
					oid_dot_zero  = oid_after_dot && ch == CH_ZERO;
					oid_after_dot = 1'b0;
					if (oid_hex)
						oid_accum = {oid_accum[27:0], 4'b0000} + 32'(dv);
					else
						oid_accum = oid_accum * 32'd10 + 32'(dv);
				end
			end
		end

		if (last) begin
			if (oid_err == ST_OK) begin
				if (oid_count == 0)
					oid_first_over = oid_accum > 32'd2;
				// A lone subidentifier is reported as too short even if it is also above two.
				if (oid_count == 0)
					fin = ST_TOO_SHORT;
				else if (oid_first_over)
					fin = ST_FIRST_ARC;
				else
					fin = ST_OK;
				push_subid(oid_accum, oid_count, 1'b1, 1'b1, fin);
			end else begin
				push_subid('0, '0, 1'b0, 1'b1, oid_err);
			end
			oid_accum      = '0;
			oid_count      = '0;
			oid_hex        = 1'b0;
			oid_after_dot  = 1'b0;
			oid_dot_zero   = 1'b0;
			oid_first_over = 1'b0;
			oid_err        = ST_OK;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint unsigned got,
	                             input longint unsigned want);
		if (mismatch_count < 50)
			$display("mismatch on %s: got %0h, wanted %0h", what, got, want);
		mismatch_count++;
	endtask

	// Driver: offers queued characters, holding each until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				parse_char(s_axis_tdata, s_axis_tlast);
			if (s_axis_tvalid && !s_axis_tready) begin
				// request still waiting
			end else if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (char_backlog.size() > 0) begin
				tx_item = char_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= tx_item.ch;
				s_axis_tlast  <= tx_item.last;
				tx_gap = tx_calm ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started by the stimulus process bumping hold_req.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			rx_hold_left <= 400;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// Monitor: checks each output request against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_subids.size() == 0) begin
					flag_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = pending_subids.pop_front();
					if (m_axis_tdata[31:0] !== want.value)
						flag_mismatch("subid_value", m_axis_tdata[31:0], want.value);
					if (m_axis_tdata[38:32] !== want.index)
						flag_mismatch("subid_index", m_axis_tdata[38:32], want.index);
					if (m_axis_tdata[41:39] !== want.status)
						flag_mismatch("parse_status", m_axis_tdata[41:39], want.status);
					if (m_axis_tdata[47:42] !== 6'd0)
						flag_mismatch("tdata padding", m_axis_tdata[47:42], 0);
					if (m_axis_tuser !== want.valid)
						flag_mismatch("subid_valid", m_axis_tuser, want.valid);
					if (m_axis_tlast !== want.eoo)
						flag_mismatch("end_of_oid", m_axis_tlast, want.eoo);
				end
			end
			if (rx_hold_left > 0) begin
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_gap = rx_calm ? 0 : pick_gap();
			end
		end
	end

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			oid_text.push_back(s[i]);
	endtask

	task automatic flush_text();
		text_item_t it;
		for (int i = 0; i < oid_text.size(); i++) begin
			it.ch   = oid_text[i];
			it.last = (i == oid_text.size() - 1);
			char_backlog.push_back(it);
		end
		phase_items += oid_text.size();
		oid_text.delete();
	endtask

	function automatic int digit_run();
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 72) return $urandom_range(2, 1);
		if (r < 95) return $urandom_range(5, 3);
		return $urandom_range(12, 8);
	endfunction

	task automatic add_digits(input bit hex, input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(hex ? 21 : 9);
			if (r < 10)
				oid_text.push_back(CH_ZERO + 8'(r));
			else if (r < 16)
				oid_text.push_back(CH_LA + 8'(r - 10));
			else
				oid_text.push_back(CH_UA + 8'(r - 16));
		end
	endtask

	// A mostly well-formed identifier, sometimes with one character spoilt.
	task automatic build_oid(input int lim);
		int n;
		int r;
		int pos;
		r = $urandom_range(99);
		if (r < ((lim <= 8) ? 25 : 2))
			n = $urandom_range(lim + 1, lim - 1);
		else if (r < 85)
			n = $urandom_range((lim < 6) ? lim : 6, 1);
		else
			n = $urandom_range((lim < 12) ? lim + 1 : 12, 1);
		if ($urandom_range(19) == 0)
			oid_text.push_back(CH_COLON);
		if ($urandom_range(99) < 85)
			oid_text.push_back(CH_ZERO + 8'($urandom_range(2)));
		else
			add_digits(1'b0, digit_run() + 1);
		for (int i = 1; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				oid_text.push_back(CH_DOT);
				add_digits(1'b0, digit_run());
			end else if (r < 85) begin
				oid_text.push_back(CH_COLON);
				add_digits(1'b1, digit_run());
			end else begin
				add_text(".0x");
				add_digits(1'b1, digit_run());
			end
		end
		if ($urandom_range(9) == 0)
			oid_text.push_back($urandom_range(1) ? CH_DOT : CH_COLON);
		if ($urandom_range(99) < 12) begin
			pos = $urandom_range(oid_text.size() - 1);
			oid_text[pos] = 8'($urandom_range(255));
		end
		flush_text();
	endtask

	task automatic build_noise();
		int n;
		logic [7:0] pick [13];
		pick = '{CH_DOT, CH_COLON, CH_X, CH_ZERO, CH_NINE, CH_LA, CH_LF, CH_UA, CH_UF,
		         8'h67, 8'h47, 8'h2F, 8'h40};
		n = $urandom_range(6, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1))
				oid_text.push_back(pick[$urandom_range(12)]);
			else
				oid_text.push_back(8'($urandom_range(255)));
		end
		flush_text();
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = v;
	endtask

	// Returns once nothing is queued, offered or awaited, plus some idle slack.
	task automatic wait_idle();
		do @(negedge clk);
		while (char_backlog.size() != 0 || s_axis_tvalid || pending_subids.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int limits [9];
		int lim;
		limits = '{-1, 2, 0, 255, 3, 128, 7, $urandom_range(128, 2), $urandom_range(255)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		for (int p = 0; p < 9; p++) begin
			if (limits[p] >= 0)
				write_limit(8'(limits[p]));
			lim = (limit_reg < MIN_SUBIDS) ? MIN_SUBIDS :
			      (limit_reg > MAX_SUBIDS_RST) ? MAX_SUBIDS_RST : limit_reg;
			tx_calm = (p == 2) || (p == 3);
			rx_calm = (p == 2);
			phase_items = 0;
			@(negedge clk);
			if (p == 0) begin
				add_text("1.3:fF");  flush_text();
				add_text("7.");      flush_text();
				add_text("0.0xA");   flush_text();
				add_text("9");       flush_text();
				add_text("1.g");     flush_text();
				oid_text.push_back(8'hFF); flush_text();
				oid_text.push_back(8'h00); flush_text();
				add_text("2.39:");   flush_text();
			end
			if (p == 1) begin
				add_text("1.2.3");
				flush_text();
			end
			// One identifier that runs past the largest limit, reaching the top index.
			if (p == 3 || p == 5) begin
				for (int i = 0; i <= lim; i++) begin
					add_digits(1'b0, 1);
					if (i < lim)
						oid_text.push_back(CH_DOT);
				end
				flush_text();
			end
			// Stall the output while the input keeps coming, so the result queue fills.
			if (p == 3)
				hold_req++;
			while (phase_items < 140) begin
				if ($urandom_range(99) < 78)
					build_oid(lim);
				else
					build_noise();
			end
			wait_idle();
		end

		if (mismatch_count == 0 && pending_subids.size() == 0)
			$display("PASS oid_dotted_text_parser_core");
		else
			$display("FAIL oid_dotted_text_parser_core");
		$finish;
	end

	initial begin
		#6000000;
		$display("FAIL oid_dotted_text_parser_core");
		$finish;
	end

endmodule
